### rtl/u8u16_pkg.sv
// Shared constants and types for the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

    // Default number of entries in the run queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // UTF-16 code units
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Code point limits
    localparam logic [20:0] MAX_POINT = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST = 21'h00D800;
    localparam logic [20:0] SURR_LAST = 21'h00DFFF;
    localparam logic [20:0] BMP_LAST = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE = 21'h010000;

    // One run of code units caused by a single input byte:
    // n_fffd replacements first, then the tail units unit_a and unit_b.
    typedef struct packed {
        logic [2:0]  total;
        logic [1:0]  n_fffd;
        logic [15:0] unit_a;
        logic [15:0] unit_b;
    } run_t;

endpackage

`default_nettype wire

### rtl/u8u16_byte_if.sv
// Input channel: one UTF-8 byte per transfer with an end-of-string flag.
`default_nettype none

interface u8u16_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_string;

    modport source (output valid, output byte_in, output end_of_string, input ready);
    modport sink (input valid, input byte_in, input end_of_string, output ready);

endinterface

`default_nettype wire

### rtl/u8u16_unit_if.sv
// Output channel: one UTF-16 code unit per transfer with an end-of-run flag.
`default_nettype none

interface u8u16_unit_if;

    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_of_run;

    modport source (output valid, output code_unit, output last_of_run, input ready);
    modport sink (input valid, input code_unit, input last_of_run, output ready);

endinterface

`default_nettype wire

### rtl/utf8_to_utf16_decoder.sv
// Throughput: one byte per cycle while the run queue has room; each run is
// registered in the queue, and the serializer sends one code unit per cycle
// from the queue head while units.ready is high.
// Reset: rst_n asynchronously clears the pending sequence, the run queue
// pointers and the unit index; queue contents are not cleared.
// Top level: UTF-8 to UTF-16 decoder.
`default_nettype none

module utf8_to_utf16_decoder
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    u8u16_byte_if.sink    bytes,
    u8u16_unit_if.source  units
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    run_t push_run;
    run_t head_run;

    // Classify bytes and build runs
    u8u16_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .q_full (q_full),
        .push   (q_push),
        .run    (push_run)
    );

    // Buffer runs between the two sides
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_run  (push_run),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_run)
    );

    // Send runs out one code unit at a time
    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (q_not_empty),
        .head      (head_run),
        .pop       (q_pop),
        .units     (units)
    );

endmodule

`default_nettype wire

### rtl/u8u16_front.sv
// Front end: classifies each byte, tracks the pending sequence, builds runs.
`default_nettype none

module u8u16_front
    import u8u16_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    u8u16_byte_if.sink   bytes,
    input  wire logic    q_full,
    output logic         push,
    output run_t         run
);

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  expected_reg, expected_next;
    logic [1:0]  accepted_reg, accepted_next;

    logic        accept;
    logic        pending;
    logic        is_cont;
    logic        fresh;
    logic [1:0]  acc_inc;
    logic [20:0] cp_ext;
    logic [20:0] cp_off;
    logic        pt_bad;
    logic        pt_pair;
    logic [15:0] pt_a;
    logic [15:0] pt_b;
    logic [1:0]  n_fffd;
    logic [1:0]  tail_cnt;
    logic [15:0] unit_a;
    logic [15:0] unit_b;

    assign bytes.ready = !q_full;
    assign accept = bytes.valid && bytes.ready;

    assign pending = (expected_reg != 2'd0);
    assign is_cont = (bytes.byte_in[7:6] == 2'b10);
    assign acc_inc = accepted_reg + 2'd1;
    assign cp_ext = {partial_reg[14:0], bytes.byte_in[5:0]};

    // Map the completed code point to one unit or a surrogate pair
    always_comb
    begin
        pt_bad = (cp_ext > MAX_POINT) || ((cp_ext >= SURR_FIRST) && (cp_ext <= SURR_LAST));
        pt_pair = !pt_bad && (cp_ext > BMP_LAST);
        cp_off = cp_ext - SUPP_BASE;
        pt_a = pt_bad ? REPLACEMENT : cp_ext[15:0];
        pt_b = REPLACEMENT;
        if (pt_pair)
        begin
            pt_a = HI_SURR_BASE + {6'd0, cp_off[19:10]};
            pt_b = LO_SURR_BASE + {6'd0, cp_off[9:0]};
        end
    end

    // Decode the byte against the pending sequence, then afresh if needed
    always_comb
    begin
        partial_next = partial_reg;
        expected_next = expected_reg;
        accepted_next = accepted_reg;
        n_fffd = 2'd0;
        tail_cnt = 2'd0;
        unit_a = REPLACEMENT;
        unit_b = REPLACEMENT;
        fresh = 1'b1;

        if (pending)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (acc_inc == expected_reg)
                begin
                    tail_cnt = pt_pair ? 2'd2 : 2'd1;
                    unit_a = pt_a;
                    unit_b = pt_b;
                    partial_next = '0;
                    expected_next = 2'd0;
                    accepted_next = 2'd0;
                end
                else if (bytes.end_of_string)
                begin
                    n_fffd = acc_inc + 2'd1;
                    partial_next = '0;
                    expected_next = 2'd0;
                    accepted_next = 2'd0;
                end
                else
                begin
                    partial_next = cp_ext;
                    accepted_next = acc_inc;
                end
            end
            else
            begin
                n_fffd = accepted_reg + 2'd1;
                partial_next = '0;
                expected_next = 2'd0;
                accepted_next = 2'd0;
            end
        end

        if (fresh)
        begin
            priority if (!bytes.byte_in[7])
            begin
                tail_cnt = 2'd1;
                unit_a = {8'h00, bytes.byte_in};
            end
            else if (bytes.byte_in[7:5] == 3'b110)
            begin
                if (bytes.end_of_string)
                begin
                    tail_cnt = 2'd1;
                end
                else
                begin
                    partial_next = {16'd0, bytes.byte_in[4:0]};
                    expected_next = 2'd1;
                    accepted_next = 2'd0;
                end
            end
            else if (bytes.byte_in[7:4] == 4'b1110)
            begin
                if (bytes.end_of_string)
                begin
                    tail_cnt = 2'd1;
                end
                else
                begin
                    partial_next = {17'd0, bytes.byte_in[3:0]};
                    expected_next = 2'd2;
                    accepted_next = 2'd0;
                end
            end
            else if (bytes.byte_in[7:3] == 5'b11110)
            begin
                if (bytes.end_of_string)
                begin
                    tail_cnt = 2'd1;
                end
                else
                begin
                    partial_next = {18'd0, bytes.byte_in[2:0]};
                    expected_next = 2'd3;
                    accepted_next = 2'd0;
                end
            end
            else
            begin
                tail_cnt = 2'd1;
            end
        end
    end

    // Assemble the run; bytes that only start or extend a sequence push nothing
    always_comb
    begin
        run.n_fffd = n_fffd;
        run.total = {1'b0, n_fffd} + {1'b0, tail_cnt};
        run.unit_a = unit_a;
        run.unit_b = unit_b;
        push = accept && (run.total != 3'd0);
    end

    // Advance the sequence state on each byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            expected_reg <= 2'd0;
            accepted_reg <= 2'd0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            expected_reg <= expected_next;
            accepted_reg <= accepted_next;
        end
    end

`ifndef SYNTHESIS
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bytes.end_of_string) |=> (expected_reg == 2'd0))
        else $error("sequence still pending after end of string");

    a_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((run.total <= 3'd4) && ({1'b0, run.n_fffd} <= run.total)))
        else $error("malformed run pushed");
`endif

endmodule

`default_nettype wire

### rtl/u8u16_queue.sv
// Run queue between the front end and the unit serializer.
`default_nettype none

module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire run_t push_run,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output run_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    // Wrap the pointers and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed run
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("run pushed into full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

### rtl/u8u16_back.sv
// Back end: serializes the head run into code units, one per transfer.
`default_nettype none

module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     not_empty,
    input  wire run_t     head,
    output logic          pop,
    u8u16_unit_if.source  units
);

    logic [1:0] idx_reg, idx_next;
    logic [1:0] tail_idx;
    logic       is_last;
    logic       xfer;

    assign tail_idx = idx_reg - head.n_fffd;
    assign is_last = (({1'b0, idx_reg} + 3'd1) == head.total);
    assign xfer = units.valid && units.ready;
    assign pop = xfer && is_last;

    // Pick replacements first, then the tail units
    always_comb
    begin
        units.valid = not_empty;
        units.last_of_run = is_last;
        if (idx_reg < head.n_fffd)
        begin
            units.code_unit = REPLACEMENT;
        end
        else if (tail_idx == 2'd0)
        begin
            units.code_unit = head.unit_a;
        end
        else
        begin
            units.code_unit = head.unit_b;
        end
    end

    // Step through the run; drop it after its last unit
    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        units.valid |-> ({1'b0, idx_reg} < head.total))
        else $error("unit index beyond end of run");
`endif

endmodule

`default_nettype wire

### test/u8u16_tb_pkg.sv
// Code-unit scoreboard for the UTF-8 to UTF-16 decoder testbench.
`timescale 1ns / 1ps

package u8u16_tb_pkg;

    import u8u16_pkg::*;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
    } unit_exp_t;

    class utf16_scoreboard;

        unit_exp_t   units_due[$];
        logic [15:0] step_units[$];
        logic [20:0] point_acc;
        logic [1:0]  cont_need;
        logic [1:0]  cont_seen;
        int          errors;
        int          bytes_noted;
        int          units_checked;
        int          pair_count;
        int          fffd_count;
        int          drop_count;

        function new();
            point_acc = '0;
            cont_need = '0;
            cont_seen = '0;
            errors = 0;
            bytes_noted = 0;
            units_checked = 0;
            pair_count = 0;
            fffd_count = 0;
            drop_count = 0;
        endfunction

        // Append one code unit to the run of the current byte
        function void add_unit(logic [15:0] cu);
            step_units.insert(step_units.size(), cu);
        endfunction

        // Emit one code point, as a surrogate pair above the BMP
        function void push_point(logic [20:0] cp);
            logic [20:0] v;
            if (cp > MAX_POINT || (cp >= SURR_FIRST && cp <= SURR_LAST))
                cp = {5'd0, REPLACEMENT};
            if (cp <= BMP_LAST) begin
                add_unit(cp[15:0]);
            end
            else begin
                v = cp - SUPP_BASE;
                add_unit(HI_SURR_BASE + {6'd0, v[19:10]});
                add_unit(LO_SURR_BASE + {6'd0, v[9:0]});
                pair_count++;
            end
        endfunction

        // Replace the lead and every continuation taken so far, then clear
        function void drop_sequence();
            add_unit(REPLACEMENT);
            for (int k = 0; k < cont_seen; k++)
                add_unit(REPLACEMENT);
            point_acc = '0;
            cont_need = '0;
            cont_seen = '0;
            drop_count++;
        endfunction

        // Work out the code units that one accepted byte causes
        function void decode_byte(logic [7:0] b, logic eos);
            logic [1:0]  need;
            logic [20:0] bits;
            bit          fresh;
            unit_exp_t   e;
            step_units.delete();
            fresh = 1'b1;
            need = '0;
            bits = '0;
            bytes_noted++;

            // extend, complete or break a pending sequence
            if (cont_need != 0) begin
                if (b[7:6] == 2'b10) begin
                    fresh = 1'b0;
                    point_acc = {point_acc[14:0], b[5:0]};
                    cont_seen = cont_seen + 2'd1;
                    if (cont_seen == cont_need) begin
                        push_point(point_acc);
                        point_acc = '0;
                        cont_need = '0;
                        cont_seen = '0;
                    end
                    else if (eos) begin
                        drop_sequence();
                    end
                end
                else begin
                    drop_sequence();
                end
            end

            // decode the byte as a lead
            if (fresh) begin
                if (b[7] == 1'b0) begin
                    add_unit({8'h00, b});
                end
                else if (b[7:5] == 3'b110) begin
                    need = 2'd1;
                    bits = {16'd0, b[4:0]};
                end
                else if (b[7:4] == 4'b1110) begin
                    need = 2'd2;
                    bits = {17'd0, b[3:0]};
                end
                else if (b[7:3] == 5'b11110) begin
                    need = 2'd3;
                    bits = {18'd0, b[2:0]};
                end
                else begin
                    add_unit(REPLACEMENT);
                end
                if (need != 0) begin
                    if (eos) begin
                        add_unit(REPLACEMENT);
                    end
                    else begin
                        point_acc = bits;
                        cont_need = need;
                        cont_seen = '0;
                    end
                end
            end

            // queue the run, flagging its final unit
            foreach (step_units[i]) begin
                e.code_unit = step_units[i];
                e.last_of_run = (i == step_units.size() - 1);
                if (step_units[i] == REPLACEMENT)
                    fffd_count++;
                units_due.insert(units_due.size(), e);
            end
        endfunction

        // Compare one transferred code unit with the oldest one due
        function void check_unit(logic [15:0] cu, logic last);
            unit_exp_t e;
            units_checked++;
            if (units_due.size() == 0) begin
                $display("%0t: unexpected code unit %h last_of_run %b", $time, cu, last);
                errors++;
                return;
            end
            e = units_due.pop_front();
            if (cu !== e.code_unit) begin
                $display("%0t: code_unit expected %h actual %h", $time, e.code_unit, cu);
                errors++;
            end
            if (last !== e.last_of_run) begin
                $display("%0t: last_of_run expected %b actual %b (unit %h)",
                         $time, e.last_of_run, last, cu);
                errors++;
            end
        endfunction

    endclass

endpackage

### test/tb_top.sv
// Top-level testbench for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

module tb_top;

    import u8u16_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 51;

    logic clk;
    logic rst_n;

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    int quiet_cycles;

    logic [7:0] plan_byte[$];
    logic       plan_eos[$];

    utf16_scoreboard sb;

    u8u16_byte_if byte_ch();
    u8u16_unit_if unit_ch();

    utf8_to_utf16_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .units (unit_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            unit_ch.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            unit_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Note every byte transfer and check every unit transfer
    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            sb.decode_byte(byte_ch.byte_in, byte_ch.end_of_string);
        if (rst_n && unit_ch.valid && unit_ch.ready)
            sb.check_unit(unit_ch.code_unit, unit_ch.last_of_run);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    task automatic plan_add(input logic [7:0] b, input logic eos);
        plan_byte.insert(plan_byte.size(), b);
        plan_eos.insert(plan_eos.size(), eos);
    endtask

    // Append a lead byte for a sequence of the given total length
    task automatic plan_lead(input int len, input logic eos);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        case (len)
            1: plan_add({1'b0, r[6:0]}, eos);
            2: plan_add({3'b110, r[4:0]}, eos);
            3: plan_add({4'b1110, r[3:0]}, eos);
            default: plan_add({5'b11110, r[2:0]}, eos);
        endcase
    endtask

    task automatic plan_cont(input logic eos);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        plan_add({2'b10, r[5:0]}, eos);
    endtask

    // Append one random sequence: mostly well formed, some broken, some noise
    task automatic plan_random_seq();
        int         kind;
        int         len;
        int         conts;
        logic [7:0] r;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            len = $urandom_range(1, 4);
            if (len == 1)
            begin
                plan_lead(1, $urandom_range(0, 7) == 0);
            end
            else
            begin
                plan_lead(len, 1'b0);
                for (int k = 1; k < len - 1; k++)
                    plan_cont(1'b0);
                plan_cont($urandom_range(0, 7) == 0);
            end
        end
        else if (kind < 85)
        begin
            len = $urandom_range(2, 4);
            conts = $urandom_range(0, len - 2);
            if ($urandom_range(0, 1) == 0)
            begin
                // end the string early
                if (conts == 0)
                begin
                    plan_lead(len, 1'b1);
                end
                else
                begin
                    plan_lead(len, 1'b0);
                    for (int k = 1; k < conts; k++)
                        plan_cont(1'b0);
                    plan_cont(1'b1);
                end
            end
            else
            begin
                // break the sequence with a byte that is not a continuation
                plan_lead(len, 1'b0);
                for (int k = 0; k < conts; k++)
                    plan_cont(1'b0);
                r = 8'($urandom_range(0, 255));
                if (r[7:6] == 2'b10)
                    r[6] = 1'b1;
                plan_add(r, $urandom_range(0, 3) == 0);
            end
        end
        else
        begin
            plan_add(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    // Edge cases: extremes, every lead class, overlong, surrogate,
    // out of range, broken sequence and early end
    task automatic plan_directed();
        plan_add(8'h00, 1'b0);
        plan_add(8'h7F, 1'b1);
        plan_add(8'h80, 1'b0);
        plan_add(8'hC0, 1'b0);
        plan_add(8'h80, 1'b0);
        plan_add(8'hED, 1'b0);
        plan_add(8'hA0, 1'b0);
        plan_add(8'h80, 1'b0);
        plan_add(8'hF0, 1'b0);
        plan_add(8'h90, 1'b0);
        plan_add(8'h80, 1'b0);
        plan_add(8'h80, 1'b0);
        plan_add(8'hF7, 1'b0);
        plan_add(8'hBF, 1'b0);
        plan_add(8'hBF, 1'b0);
        plan_add(8'hBF, 1'b1);
        plan_add(8'hE2, 1'b0);
        plan_add(8'h82, 1'b0);
        plan_add(8'h41, 1'b0);
        plan_add(8'hF0, 1'b0);
        plan_add(8'h90, 1'b0);
        plan_add(8'h80, 1'b0);
        plan_add(8'hFF, 1'b0);
        plan_add(8'hE2, 1'b0);
        plan_add(8'h82, 1'b1);
        plan_add(8'hC3, 1'b1);
    endtask

    // Offer one byte, idling first at random, and hold it until transferred
    task automatic send_byte(input logic [7:0] b, input logic eos);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.byte_in <= 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.byte_in <= b;
        byte_ch.end_of_string <= eos;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    // Send the whole plan, then drop valid and wait for every unit due
    task automatic send_plan();
        while (plan_byte.size() != 0)
            send_byte(plan_byte.pop_front(), plan_eos.pop_front());
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.units_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        while (plan_byte.size() < PHASE_ITEMS)
            plan_random_seq();
        send_plan();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        byte_ch.valid = 1'b0;
        byte_ch.byte_in = 8'h00;
        byte_ch.end_of_string = 1'b0;
        unit_ch.ready = 1'b0;

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed edge cases at full rate
        plan_directed();
        send_plan();

        // Full rate with a long receiver hold-off so the block backs up
        hold_left = HOLD_CYCLES;
        run_phase(0, 0);

        run_phase(66, 0);
        run_phase(0, 66);
        run_phase(22, 22);

        // Let any late unit show up
        repeat (8) @(posedge clk);
        if (sb.units_due.size() != 0)
        begin
            $display("%0t: %0d code units never arrived", $time, sb.units_due.size());
            sb.errors++;
        end

        $display("Covered %0d bytes and %0d code units over five idle/stall mixes,",
                 sb.bytes_noted, sb.units_checked);
        $display("  with %0d surrogate pairs, %0d replacements, %0d dropped sequences",
                 sb.pair_count, sb.fffd_count, sb.drop_count);
        if (sb.errors == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
